// ----- sv/rip_pkg.sv -----
// Shared constants and widths for the row interleave packer.
// No dependencies; the interfaces, the packer and the testbench import this package.
`default_nettype none

package rip_pkg;

    localparam int MAX_FACTOR  = 16;
    localparam int MAX_COLUMNS = 256;

    localparam int ELEM_W   = 64;
    localparam int FACTOR_W = 5;
    localparam int LEN_W    = 9;
    localparam int MODE_W   = 3;
    localparam int ROW_W    = $clog2(MAX_FACTOR);
    localparam int COL_W    = $clog2(MAX_COLUMNS);
    localparam int PAIR_W   = ROW_W - 1;

    // Even rows in one bank, odd rows in the other.
    localparam int BANK_DEPTH = (MAX_FACTOR / 2) * MAX_COLUMNS;
    localparam int BANK_AW    = PAIR_W + COL_W;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] REG_GROUP_FACTOR = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ROWS_USED    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ROW_LENGTH   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ELEMENT_MODE = 3'd3;

    localparam logic [MODE_W-1:0] MODE_NIB4 = 3'd0;
    localparam logic [MODE_W-1:0] MODE_B8   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_B16  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_B32  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_B64  = 3'd4;

endpackage

`default_nettype wire

// ----- sv/rip_if.sv -----
// Valid/ready channel interfaces: input beats, result beats, register writes.
// Depends on rip_pkg.
`default_nettype none

interface rip_in_if
    import rip_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element_in;

    modport source (output valid, output element_in, input ready);
    modport sink   (input valid, input element_in, output ready);
endinterface

interface rip_out_if
    import rip_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element_out;
    logic              run_last;
    logic              block_last;

    modport source (output valid, output element_out, output run_last, output block_last,
                    input ready);
    modport sink   (input valid, input element_out, input run_last, input block_last,
                    output ready);
endinterface

interface rip_cfg_if
    import rip_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// ----- sv/rip_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/row_interleave_pack.sv -----
// Row interleave packer: buffers rows, emits each column across the row group.
// Buffered-row beat: written to a row bank, no result. Last-row beat: the bank reads
// and emit state are registered, then the result register; then one result per cycle
// while dst is ready, n results (n up to 16), input held off. Reset clears counters
// and restores register defaults; the row banks are not cleared (no clearing pass).
// Depends on rip_pkg, rip_if, rip_ram.
`default_nettype none

module row_interleave_pack
    import rip_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rip_in_if.sink    src,
    rip_out_if.source dst,
    rip_cfg_if.sink   cfg
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [FACTOR_W-1:0]   factor_reg, factor_next;
    logic [FACTOR_W-1:0]   rows_reg, rows_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [ROW_W-1:0]      row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0]      col_cnt_reg, col_cnt_next;

    logic [ELEM_W-1:0]     cur_reg, cur_next;
    logic [COL_W-1:0]      ecol_reg, ecol_next;
    logic                  end_reg, end_next;
    logic [ROW_W-1:0]      idx_reg, idx_next;
    logic                  h_reg, h_next;

    logic                  out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0]     out_elem_reg, out_elem_next;
    logic                  out_run_reg, out_run_next;
    logic                  out_blk_reg, out_blk_next;

    logic [FACTOR_W-1:0]   eff_factor, eff_rows;
    logic [LEN_W-1:0]      eff_len;
    logic [ELEM_W-1:0]     mask;
    logic                  nib;
    logic [FACTOR_W-2:0]   half;

    logic [ROW_W-1:0]      rc;
    logic [COL_W-1:0]      cc;
    logic [LEN_W-1:0]      cc_inc;
    logic                  col_wrap, buffered, in_fire, out_free, last;
    logic [ELEM_W-1:0]     cur_in;
    logic [ELEM_W-1:0]     q_even, q_odd, q_sel, b0, b1;

    logic                  we_even, we_odd, re;
    logic [BANK_AW-1:0]    waddr, raddr;

    function automatic logic [ELEM_W-1:0] row_val(
        input logic [ROW_W-1:0]    r,
        input logic [FACTOR_W-1:0] rows,
        input logic [ELEM_W-1:0]   q,
        input logic [ELEM_W-1:0]   cur
    );
        logic [FACTOR_W-1:0] r1;
        r1 = {1'b0, r} + FACTOR_W'(1);
        if (r1 < rows)
            return q;
        else if (r1 == rows)
            return cur;
        else
            return '0;
    endfunction

    // Effective register values
    always_comb
    begin
        if (factor_reg == '0)
            eff_factor = FACTOR_W'(1);
        else if (factor_reg > FACTOR_W'(MAX_FACTOR))
            eff_factor = FACTOR_W'(MAX_FACTOR);
        else
            eff_factor = factor_reg;

        if (rows_reg == '0)
            eff_rows = FACTOR_W'(1);
        else if (rows_reg > eff_factor)
            eff_rows = eff_factor;
        else
            eff_rows = rows_reg;

        if (len_reg == '0)
            eff_len = LEN_W'(1);
        else if (len_reg > LEN_W'(MAX_COLUMNS))
            eff_len = LEN_W'(MAX_COLUMNS);
        else
            eff_len = len_reg;

        case (mode_reg)
            MODE_NIB4: mask = ELEM_W'(64'hFF);
            MODE_B8:   mask = ELEM_W'(64'hFF);
            MODE_B16:  mask = ELEM_W'(64'hFFFF);
            MODE_B32:  mask = ELEM_W'(64'hFFFF_FFFF);
            default:   mask = '1;
        endcase

        nib  = (mode_reg == MODE_NIB4) && (eff_factor != FACTOR_W'(1));
        half = eff_factor[FACTOR_W-1:1];
    end

    // Input side
    always_comb
    begin
        rc       = ({1'b0, row_cnt_reg} >= eff_rows) ? '0 : row_cnt_reg;
        cc       = ({1'b0, col_cnt_reg} >= eff_len) ? '0 : col_cnt_reg;
        cc_inc   = {1'b0, cc} + LEN_W'(1);
        col_wrap = (cc_inc >= eff_len);
        buffered = (({1'b0, rc} + FACTOR_W'(1)) < eff_rows);
        cur_in   = src.element_in & mask;
        in_fire  = src.valid && src.ready;
        out_free = !out_valid_reg || dst.ready;
    end

    // Emit side
    always_comb
    begin
        q_sel = idx_reg[0] ? q_odd : q_even;
        b0    = row_val({idx_reg[PAIR_W-1:0], 1'b0}, eff_rows, q_even, cur_reg);
        b1    = row_val({idx_reg[PAIR_W-1:0], 1'b1}, eff_rows, q_odd, cur_reg);
        if (nib)
            last = h_reg && (({1'b0, idx_reg} + FACTOR_W'(1)) == {1'b0, half});
        else
            last = (({1'b0, idx_reg} + FACTOR_W'(1)) == eff_factor);
    end

    always_comb
    begin
        state_next     = state_reg;
        factor_next    = factor_reg;
        rows_next      = rows_reg;
        len_next       = len_reg;
        mode_next      = mode_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        cur_next       = cur_reg;
        ecol_next      = ecol_reg;
        end_next       = end_reg;
        idx_next       = idx_reg;
        h_next         = h_reg;
        out_valid_next = out_valid_reg;
        out_elem_next  = out_elem_reg;
        out_run_next   = out_run_reg;
        out_blk_next   = out_blk_reg;
        we_even        = 1'b0;
        we_odd         = 1'b0;
        re             = 1'b0;
        waddr          = {rc[ROW_W-1:1], cc};

        if (dst.valid && dst.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    col_cnt_next = col_wrap ? '0 : cc_inc[COL_W-1:0];
                    if (buffered)
                    begin
                        we_even      = !rc[0];
                        we_odd       = rc[0];
                        row_cnt_next = col_wrap ? rc + ROW_W'(1) : rc;
                    end
                    else
                    begin
                        row_cnt_next = col_wrap ? '0 : rc;
                        cur_next     = cur_in;
                        ecol_next    = cc;
                        end_next     = col_wrap;
                        idx_next     = '0;
                        h_next       = 1'b0;
                        re           = 1'b1;
                        state_next   = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_run_next   = last;
                    out_blk_next   = last && end_reg;
                    if (nib)
                    begin
                        out_elem_next = h_reg ? ELEM_W'({b1[7:4], b0[7:4]})
                                              : ELEM_W'({b1[3:0], b0[3:0]});
                    end
                    else
                    begin
                        out_elem_next = row_val(idx_reg, eff_rows, q_sel, cur_reg) & mask;
                    end
                    if (last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        re = 1'b1;
                        if (nib && (({1'b0, idx_reg} + FACTOR_W'(1)) == {1'b0, half}))
                        begin
                            idx_next = '0;
                            h_next   = 1'b1;
                        end
                        else
                        begin
                            idx_next = idx_reg + ROW_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.valid && cfg.ready)
        begin
            case (cfg.addr)
                REG_GROUP_FACTOR:
                begin
                    factor_next  = cfg.wdata[FACTOR_W-1:0];
                    row_cnt_next = '0;
                    col_cnt_next = '0;
                end
                REG_ROWS_USED:
                begin
                    rows_next    = cfg.wdata[FACTOR_W-1:0];
                    row_cnt_next = '0;
                    col_cnt_next = '0;
                end
                REG_ROW_LENGTH:
                begin
                    len_next     = cfg.wdata[LEN_W-1:0];
                    row_cnt_next = '0;
                    col_cnt_next = '0;
                end
                REG_ELEMENT_MODE:
                begin
                    mode_next    = cfg.wdata[MODE_W-1:0];
                    row_cnt_next = '0;
                    col_cnt_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read address: input column while idle, else the result index being fetched
    always_comb
    begin
        if (state_reg == S_IDLE)
            raddr = {{PAIR_W{1'b0}}, cc};
        else if (nib)
            raddr = {idx_next[PAIR_W-1:0], ecol_reg};
        else
            raddr = {idx_next[ROW_W-1:1], ecol_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            factor_reg    <= FACTOR_W'(1);
            rows_reg      <= FACTOR_W'(1);
            len_reg       <= LEN_W'(1);
            mode_reg      <= MODE_B8;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            factor_reg    <= factor_next;
            rows_reg      <= rows_next;
            len_reg       <= len_next;
            mode_reg      <= mode_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        ecol_reg     <= ecol_next;
        end_reg      <= end_next;
        idx_reg      <= idx_next;
        h_reg        <= h_next;
        out_elem_reg <= out_elem_next;
        out_run_reg  <= out_run_next;
        out_blk_reg  <= out_blk_next;
    end

    rip_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .clk   (clk),
        .we    (we_even),
        .waddr (waddr),
        .wdata (cur_in),
        .re    (re),
        .raddr (raddr),
        .rdata (q_even)
    );

    rip_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .clk   (clk),
        .we    (we_odd),
        .waddr (waddr),
        .wdata (cur_in),
        .re    (re),
        .raddr (raddr),
        .rdata (q_odd)
    );

    assign src.ready       = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign dst.valid       = out_valid_reg;
    assign dst.element_out = out_elem_reg;
    assign dst.run_last    = out_run_reg;
    assign dst.block_last  = out_blk_reg;

    a_blk_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst.valid && dst.block_last |-> dst.run_last)
        else $error("block_last without run_last");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_cnt_reg} < eff_len)
        else $error("column counter beyond row length");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, row_cnt_reg} < eff_rows)
        else $error("row counter beyond rows used");

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst.valid) |-> $past(state_reg == S_EMIT))
        else $error("result beat loaded outside emit");

endmodule

`default_nettype wire

// ----- dv/tb_row_interleave_pack.sv -----
`timescale 1ns / 1ps
// Testbench for row_interleave_pack: random row groups under random backpressure,
// each result beat checked against an in-bench model of the interleaver.
// Depends on rip_pkg, rip_if and the row_interleave_pack RTL.

module tb_row_interleave_pack;
    import rip_pkg::*;

    localparam int NUM_REGS       = 4;
    localparam int SETTLE         = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int PRESSURE_BEATS = 64;
    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam int MAX_SHOWN      = 10;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              run_last;
        logic              block_last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;

    rip_in_if  in_ch ();
    rip_out_if out_ch ();
    rip_cfg_if cfg_ch ();

    row_interleave_pack i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (in_ch),
        .dst   (out_ch),
        .cfg   (cfg_ch)
    );

    always #4 clk = ~clk;

    // model state
    logic [ELEM_W-1:0]   row_mem [(MAX_FACTOR-1)*MAX_COLUMNS];
    logic [FACTOR_W-1:0] r_factor;
    logic [FACTOR_W-1:0] r_rows;
    logic [LEN_W-1:0]    r_len;
    logic [MODE_W-1:0]   r_mode;
    int unsigned         row_cnt;
    int unsigned         col_cnt;

    result_t           result_q [$];
    logic [ELEM_W-1:0] beat_q [$];
    int                pushed      = 0;
    int                accepted    = 0;
    int                mismatches  = 0;
    int                cycles      = 0;
    int                in_idle_pct  = 0;
    int                out_idle_pct = 0;
    bit                no_idle     = 1'b0;
    bit                in_taken    = 1'b0;
    bit                hold_go     = 1'b0;
    bit                hold_done   = 1'b0;
    int                hold_left   = 0;
    int                in_gap      = 0;
    int                out_stall   = 0;

    function automatic int unsigned eff_factor(input logic [FACTOR_W-1:0] f);
        if (f == 0)
            return 1;
        if (f > MAX_FACTOR)
            return MAX_FACTOR;
        return f;
    endfunction

    function automatic int unsigned eff_rows(input logic [FACTOR_W-1:0] f,
                                             input logic [FACTOR_W-1:0] r);
        int unsigned nf;
        nf = eff_factor(f);
        if (r == 0)
            return 1;
        if (r > nf)
            return nf;
        return r;
    endfunction

    function automatic int unsigned eff_len(input logic [LEN_W-1:0] l);
        if (l == 0)
            return 1;
        if (l > MAX_COLUMNS)
            return MAX_COLUMNS;
        return l;
    endfunction

    function automatic logic [ELEM_W-1:0] elem_mask(input logic [MODE_W-1:0] md);
        case (md)
            MODE_NIB4, MODE_B8: return 64'hFF;
            MODE_B16:           return 64'hFFFF;
            MODE_B32:           return 64'hFFFF_FFFF;
            default:            return '1;
        endcase
    endfunction

    function automatic logic [ELEM_W-1:0] any_element();
        return {$urandom, $urandom};
    endfunction

    // Row r of the current column: buffered, the live beat, or zero padding.
    function automatic logic [ELEM_W-1:0] row_elem(input int unsigned r, input int unsigned nr,
                                                   input int unsigned col,
                                                   input logic [ELEM_W-1:0] cur);
        if (r + 1 < nr)
            return row_mem[r*MAX_COLUMNS + col];
        if (r + 1 == nr)
            return cur;
        return '0;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_AW-1:0] a,
                                            input logic [CFG_DW-1:0] d);
        case (a)
            REG_GROUP_FACTOR: r_factor = d[FACTOR_W-1:0];
            REG_ROWS_USED:    r_rows   = d[FACTOR_W-1:0];
            REG_ROW_LENGTH:   r_len    = d[LEN_W-1:0];
            REG_ELEMENT_MODE: r_mode   = d[MODE_W-1:0];
            default: ;
        endcase
        if (a <= REG_ELEMENT_MODE)
        begin
            row_cnt = 0;
            col_cnt = 0;
        end
    endfunction

    task automatic predict_beat(input logic [ELEM_W-1:0] din);
        int unsigned       nf;
        int unsigned       nr;
        int unsigned       nl;
        int unsigned       col;
        logic [ELEM_W-1:0] m;
        logic [ELEM_W-1:0] cur;
        logic [ELEM_W-1:0] lo;
        logic [ELEM_W-1:0] hi;
        logic [ELEM_W-1:0] vals [$];
        result_t           res;
        nf  = eff_factor(r_factor);
        nr  = eff_rows(r_factor, r_rows);
        nl  = eff_len(r_len);
        m   = elem_mask(r_mode);
        cur = din & m;
        if (row_cnt >= nr)
            row_cnt = 0;
        if (col_cnt >= nl)
            col_cnt = 0;
        col = col_cnt;
        if (row_cnt + 1 < nr)
        begin
            row_mem[row_cnt*MAX_COLUMNS + col] = cur;
            col_cnt = col + 1;
            if (col_cnt >= nl)
            begin
                col_cnt = 0;
                row_cnt++;
            end
        end
        else
        begin
            if (nf == 1)
                vals.push_back(cur);
            else if (r_mode == MODE_NIB4)
            begin
                for (int h = 0; h < 2; h++)
                begin
                    for (int i = 0; i < nf / 2; i++)
                    begin
                        lo = (row_elem(2*i, nr, col, cur) >> (4*h)) & 64'hF;
                        hi = (row_elem(2*i + 1, nr, col, cur) >> (4*h)) & 64'hF;
                        vals.push_back(lo | (hi << 4));
                    end
                end
            end
            else
            begin
                for (int r = 0; r < nf; r++)
                    vals.push_back(row_elem(r, nr, col, cur) & m);
            end
            for (int k = 0; k < vals.size(); k++)
            begin
                res.element    = vals[k];
                res.run_last   = (k == vals.size() - 1);
                res.block_last = res.run_last && (col + 1 >= nl);
                result_q.push_back(res);
            end
            col_cnt = col + 1;
            if (col_cnt >= nl)
            begin
                col_cnt = 0;
                row_cnt = 0;
            end
        end
    endtask

    // monitor: register writes, input beats and result beats
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            r_factor = 1;
            r_rows   = 1;
            r_len    = 1;
            r_mode   = MODE_B8;
            row_cnt  = 0;
            col_cnt  = 0;
        end
        else
        begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready)
            begin
                if (result_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result beat: element %h run_last %b block_last %b",
                                 out_ch.element_out, out_ch.run_last, out_ch.block_last);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (out_ch.element_out !== want.element || out_ch.run_last !== want.run_last
                        || out_ch.block_last !== want.block_last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     want.element, want.run_last, want.block_last,
                                     out_ch.element_out, out_ch.run_last, out_ch.block_last);
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                apply_reg_write(cfg_ch.addr, cfg_ch.wdata);
            if (in_ch.valid && in_ch.ready)
            begin
                accepted++;
                predict_beat(in_ch.element_in);
            end
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_gap      <= 0;
        end
        else if (!(in_ch.valid && !in_taken))
        begin
            if (in_gap != 0)
            begin
                in_ch.valid <= 1'b0;
                in_gap      <= in_gap - 1;
            end
            else if (beat_q.size() != 0 && !no_idle && $urandom_range(0, 99) < in_idle_pct)
            begin
                in_ch.valid <= 1'b0;
                in_gap      <= $urandom_range(0, 14);
            end
            else if (beat_q.size() != 0)
            begin
                in_ch.valid      <= 1'b1;
                in_ch.element_in <= beat_q.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // long receiver hold-off, counted here
    always @(negedge clk)
    begin
        if (hold_go && !hold_done && hold_left == 0)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                hold_done <= 1'b1;
        end
    end

    // result sink
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_stall    <= 0;
        end
        else if (hold_left != 0)
            out_ch.ready <= 1'b0;
        else if (out_stall != 0)
        begin
            out_ch.ready <= 1'b0;
            out_stall    <= out_stall - 1;
        end
        else if (!no_idle && $urandom_range(0, 99) < out_idle_pct)
        begin
            out_ch.ready <= 1'b0;
            out_stall    <= $urandom_range(0, 14);
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("row_interleave_pack test failed");
            $finish;
        end
    end

    function automatic void offer(input logic [ELEM_W-1:0] v);
        beat_q.push_back(v);
        pushed++;
    endfunction

    task automatic drain();
        @(negedge clk);
        while (accepted != pushed || result_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= a;
        cfg_ch.wdata <= d;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // unused upper data bits are random
    task automatic program_regs(input int f, input int r, input int l, input int m,
                                input logic [NUM_REGS-1:0] sel);
        logic [CFG_DW-1:0] d;
        if (sel[REG_GROUP_FACTOR])
        begin
            d = CFG_DW'($urandom);
            d[FACTOR_W-1:0] = FACTOR_W'(f);
            write_reg(REG_GROUP_FACTOR, d);
        end
        if (sel[REG_ROWS_USED])
        begin
            d = CFG_DW'($urandom);
            d[FACTOR_W-1:0] = FACTOR_W'(r);
            write_reg(REG_ROWS_USED, d);
        end
        if (sel[REG_ROW_LENGTH])
        begin
            d = CFG_DW'($urandom);
            d[LEN_W-1:0] = LEN_W'(l);
            write_reg(REG_ROW_LENGTH, d);
        end
        if (sel[REG_ELEMENT_MODE])
        begin
            d = CFG_DW'($urandom);
            d[MODE_W-1:0] = MODE_W'(m);
            write_reg(REG_ELEMENT_MODE, d);
        end
    endtask

    initial
    begin : stimulus
        int f;
        int r;
        int l;
        int m;
        int x;
        int grp;
        int n;
        int phase;
        int random_beats;
        logic [NUM_REGS-1:0] sel;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.element_in = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.addr      = '0;
        cfg_ch.wdata     = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: 8-bit pass-through
        @(posedge clk);
        offer('1);
        offer('0);
        drain();

        // nibble pairs with a padded row
        program_regs(4, 3, 2, MODE_NIB4, '1);
        @(posedge clk);
        offer('1);
        repeat (5) offer(any_element());
        drain();

        // odd factor in nibble mode drops the last row
        program_regs(3, 3, 1, MODE_NIB4, '1);
        @(posedge clk);
        repeat (3) offer(any_element());
        drain();

        // widest factor, mostly padding
        program_regs(MAX_FACTOR, 2, 1, MODE_B64, '1);
        @(posedge clk);
        offer('1);
        offer(any_element());
        drain();

        // zero settings and an unknown mode
        program_regs(0, 0, 0, MODE_B64 + 3, '1);
        @(posedge clk);
        offer('1);
        offer(any_element());
        drain();

        // a write mid-group restarts; a write to an unused index does not
        program_regs(2, 2, 2, MODE_B32, '1);
        @(posedge clk);
        offer(any_element());
        drain();
        program_regs(0, 2, 0, 0, 4'b0010);
        @(posedge clk);
        offer(any_element());
        offer(any_element());
        drain();
        write_reg(CFG_AW'($urandom_range(NUM_REGS, 2**CFG_AW - 1)), CFG_DW'($urandom));
        @(posedge clk);
        offer(any_element());
        offer(any_element());
        drain();

        random_beats = 0;
        phase        = 0;
        while (random_beats < 300)
        begin
            if (phase == 0)
            begin
                f = MAX_FACTOR; r = MAX_FACTOR; l = 1; m = MODE_B64; sel = '1;
            end
            else if (phase == 3)
            begin
                f = 3; r = 1; l = 2**LEN_W - 1; m = MODE_B16; sel = '1;
            end
            else
            begin
                x = $urandom_range(0, 9);
                f = (x == 0) ? 0 : (x == 1) ? $urandom_range(MAX_FACTOR + 1, 31)
                                            : $urandom_range(1, MAX_FACTOR);
                r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(1, eff_factor(f));
                x = $urandom_range(0, 19);
                l = (x < 14) ? $urandom_range(1, 6) : (x < 18) ? $urandom_range(7, 24)
                  : (x == 18) ? 0 : $urandom_range(MAX_COLUMNS + 1, 2**LEN_W - 1);
                m = ($urandom_range(0, 9) < 8) ? $urandom_range(MODE_NIB4, MODE_B64)
                                              : $urandom_range(MODE_B64 + 1, 2**MODE_W - 1);
                sel = ($urandom_range(0, 3) == 0)
                    ? NUM_REGS'($urandom_range(1, 2**NUM_REGS - 1)) : '1;
            end
            program_regs(f, r, l, m, sel);
            grp = eff_rows(r_factor, r_rows) * eff_len(r_len);
            if (phase == 3)
                n = PRESSURE_BEATS;
            else if (grp <= 48)
                n = grp * $urandom_range(1, 3)
                  + (($urandom_range(0, 4) == 0) ? $urandom_range(1, grp) : 0);
            else
                n = $urandom_range(1, 40);
            @(posedge clk);
            in_idle_pct  = (phase == 3) ? 0 : 20 * $urandom_range(0, 3);
            out_idle_pct = 20 * $urandom_range(0, 3);
            no_idle      = (random_beats >= 240);
            if (phase == 3)
                hold_go = 1'b1;
            repeat (n) offer(any_element());
            random_beats += n;
            phase++;
            drain();
        end

        if (mismatches == 0 && result_q.size() == 0)
            $display("row_interleave_pack test passed");
        else
            $display("row_interleave_pack test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/rip_pkg.sv
sv/rip_if.sv
sv/rip_ram.sv
sv/row_interleave_pack.sv
dv/tb_row_interleave_pack.sv
